// ===== hdl/pev_pkg.sv =====
package pev_pkg;

    localparam int MAX_TERMS_DEF = 64;
    localparam int COEF_W        = 32;
    localparam int POINT_W       = 32;
    localparam int VALUE_W       = 64;
    localparam int TERMS_W       = 7;

    // input word kinds carried on tuser
    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_EVAL   = 1'b1;

    // control word from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic lo_step;
        logic hi_step;
    } t_mac_ctrl;

endpackage

// ===== hdl/pev_coef_mem.sv =====
module pev_coef_mem
    import pev_pkg::*;
#(
    parameter int DEPTH  = MAX_TERMS_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [COEF_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [COEF_W-1:0] o_rd_data
);

    logic [COEF_W-1:0] r_mem [DEPTH];
    logic [COEF_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/pev_mac_unit.sv =====
module pev_mac_unit
    import pev_pkg::*;
(
    input  logic                i_clk,
    input  t_mac_ctrl           i_ctrl,
    input  logic [POINT_W-1:0]  i_point,
    input  logic [COEF_W-1:0]   i_coef,
    output logic [VALUE_W-1:0]  o_acc
);

    logic [VALUE_W-1:0]   r_acc;
    logic [VALUE_W-1:0]   r_prod;
    logic [32:0]          mul_a;
    logic signed [65:0]   mul_p;
    logic [VALUE_W-1:0]   coef_ext;

    // one 33x32 signed multiplier, used twice per term:
    // low half of acc (zero-extended) times x, then high half times x mod 2^32
    assign mul_a    = i_ctrl.lo_step ? {1'b0, r_acc[31:0]} : {r_acc[63], r_acc[63:32]};
    assign mul_p    = $signed(mul_a) * $signed({i_point[POINT_W-1], i_point});
    assign coef_ext = {{(VALUE_W-COEF_W){i_coef[COEF_W-1]}}, i_coef};

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_acc <= '0;
        end else if (i_ctrl.hi_step) begin
            r_acc <= r_prod + {mul_p[31:0], 32'd0} + coef_ext;
        end
        if (i_ctrl.lo_step) begin
            r_prod <= mul_p[VALUE_W-1:0];
        end
    end

    assign o_acc = r_acc;

endmodule

// ===== hdl/polynomial_evaluator_unit.sv =====
// polynomial evaluator, horner form, exact integer arithmetic mod 2^64
//
// input stream s_axis: tuser selects the word kind. tuser = 0 appends
// tdata[31:0] as the next coefficient (lowest power first); tuser = 1
// evaluates the stored polynomial at x = tdata[63:32]. appends beyond
// MAX_TERMS are dropped and reported by the sticky dropped flag.
// output stream m_axis: one word per evaluate, tdata = value[63:0],
// terms_used[70:64], dropped[71]. appends produce no output word.
//
// after an append tready stays high. an evaluate runs from acceptance to the
// result in the output register with tready low meanwhile. it is served by
// the single shared 33x32 multiplier, which makes a low pass and a high pass
// on each term (low and high half of the 64-bit accumulator), fed from a
// coefficient memory with one read port.
// the output register holds a finished result while the receiver stalls;
// appends are still taken then, and a further evaluate waits for the slot.
// synchronous active-low reset empties the coefficient list and clears the
// dropped flag and the output valid; the memory itself is not cleared.
module polynomial_evaluator_unit
    import pev_pkg::*;
#(
    parameter int MAX_TERMS = MAX_TERMS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // coefficient[31:0], point[63:32]
    input  logic        s_axis_tuser,  // kind[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata   // value[63:0], terms_used[70:64], dropped[71]
);

    localparam int CNT_W  = $clog2(MAX_TERMS + 1);
    localparam int ADDR_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MLO  = 2'd1;
    localparam logic [1:0] ST_MHI  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic                r_ovf, n_ovf;
    logic [POINT_W-1:0]  r_x;
    logic                r_out_valid;
    logic [VALUE_W-1:0]  r_out_value;
    logic [TERMS_W-1:0]  r_out_terms;
    logic                r_out_drop;

    t_mac_ctrl           mac_ctrl;
    logic                wr_en;
    logic                s_accept;
    logic                out_load;
    logic [ADDR_W-1:0]   rd_addr;
    logic [COEF_W-1:0]   rd_data;
    logic [VALUE_W-1:0]  acc;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_load      = (r_state == ST_OUT) && (!r_out_valid || m_axis_tready);
    assign rd_addr       = ADDR_W'(r_idx - CNT_W'(1));

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_ovf    = r_ovf;
        mac_ctrl = '0;
        wr_en    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_axis_tuser == KIND_APPEND) begin
                        if (r_count < CNT_W'(MAX_TERMS)) begin
                            wr_en   = 1'b1;
                            n_count = r_count + CNT_W'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else begin
                        mac_ctrl.clear = 1'b1;
                        n_idx          = r_count;
                        n_state        = (r_count == '0) ? ST_OUT : ST_MLO;
                    end
                end
            end
            ST_MLO: begin
                mac_ctrl.lo_step = 1'b1;
                n_state          = ST_MHI;
            end
            ST_MHI: begin
                mac_ctrl.hi_step = 1'b1;
                n_idx            = r_idx - CNT_W'(1);
                n_state          = (r_idx == CNT_W'(1)) ? ST_OUT : ST_MLO;
            end
            ST_OUT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_ovf   <= n_ovf;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept && s_axis_tuser == KIND_EVAL) begin
            r_x <= s_axis_tdata[63:32];
        end
        if (out_load) begin
            r_out_value <= acc;
            r_out_terms <= TERMS_W'(r_count);
            r_out_drop  <= r_ovf;
        end
    end

    pev_coef_mem #(
        .DEPTH  (MAX_TERMS),
        .ADDR_W (ADDR_W)
    ) u_coef_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (ADDR_W'(r_count)),
        .i_wr_data (s_axis_tdata[31:0]),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    pev_mac_unit u_mac_unit (
        .i_clk   (i_clk),
        .i_ctrl  (mac_ctrl),
        .i_point (r_x),
        .i_coef  (rd_data),
        .o_acc   (acc)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_drop, r_out_terms, r_out_value};

endmodule

// ===== hdl/pev_checker.sv =====
module pev_checker
    import pev_pkg::*;
#(
    parameter int MAX_TERMS = MAX_TERMS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [71:0] m_axis_tdata
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // an accepted evaluate busies the block on the next cycle
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_EVAL |=> !s_axis_tready)
        else $error("input ready right after an evaluate word");

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a refused append only happens with a full store
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[71] |-> m_axis_tdata[70:64] == TERMS_W'(MAX_TERMS))
        else $error("dropped flag set with store not full");

endmodule

bind polynomial_evaluator_unit pev_checker #(
    .MAX_TERMS (MAX_TERMS)
) u_pev_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
